FILE: sv/lfds_pkg.sv
// lfds_pkg: shared types, constants and the line-delay table of the LED frame drive sequencer
// no dependencies; imported by every module of the block

package lfds_pkg;

    localparam int DELAY_ENTRIES_DEFAULT = 13;
    localparam int SCAN_CHANNELS_DEFAULT = 8;

    localparam int LEVEL_W = 12;
    localparam int CUR_W   = 12;
    localparam int DUTY_W  = 14;
    localparam int REQ_W   = 16;
    localparam int DELAY_W = 12;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 12'd4095;
    localparam logic [LEVEL_W-1:0] LEVEL_LOW   = 12'd5;
    localparam logic [CUR_W-1:0]   CUR_MAX     = 12'd2048;
    localparam logic [CUR_W-1:0]   CUR_DEFAULT = 12'd160;
    localparam logic [CUR_W-1:0]   CUR_STEP_OFFSET = 12'd16;

    localparam logic [6:0] SCAN_WAIT    = 7'd12;
    localparam logic [6:0] SCAN_HOLD    = 7'd120;
    localparam logic [5:0] DELAY_PERIOD = 6'd60;
    localparam logic [3:0] STEP_LAST    = 4'd8;

    localparam logic [8:0] SCAN_LEVEL_X8 = 9'd32;
    localparam logic [8:0] SCAN_LEVEL_X1 = 9'd256;
    localparam logic [1:0] SCAN_CODE_X8  = 2'd3;
    localparam logic [1:0] SCAN_CODE_X1  = 2'd0;

    // round-half-up of duty * 4095 / 10000 via reciprocal multiply
    localparam logic [DUTY_W-1:0] DUTY_FULL  = 14'd10000;
    localparam logic [25:0]       DUTY_HALF  = 26'd5000;
    localparam logic [26:0]       DUTY_RECIP = 27'd109951163;
    localparam int                DUTY_SHIFT = 40;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_STEP = 2'd1,
        OP_SET  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CFG_LOW_CURRENT = 2'd0,
        CFG_SCAN_TEST   = 2'd1,
        CFG_DELAY_TEST  = 2'd2,
        CFG_DUTY        = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        SCAN_WAIT_X8 = 2'd0,
        SCAN_HOLD_X8 = 2'd1,
        SCAN_WAIT_X1 = 2'd2,
        SCAN_HOLD_X1 = 2'd3
    } scan_phase_t;

    function automatic logic [DELAY_W-1:0] delay_value(input logic [3:0] idx);
        logic [DELAY_W-1:0] val;
        unique case (idx)
            4'd0:    val = 12'd0;
            4'd1:    val = 12'd1;
            4'd2:    val = 12'd2;
            4'd3:    val = 12'd4;
            4'd4:    val = 12'd8;
            4'd5:    val = 12'd16;
            4'd6:    val = 12'd32;
            4'd7:    val = 12'd64;
            4'd8:    val = 12'd128;
            4'd9:    val = 12'd256;
            4'd10:   val = 12'd512;
            4'd11:   val = 12'd1024;
            default: val = 12'd2048;
        endcase
        return val;
    endfunction

endpackage

FILE: sv/led_frame_drive_sequencer_unit.sv
// led_frame_drive_sequencer_unit: top level of the LED frame drive sequencer
// depends on lfds_pkg and lfds_duty_level
// a transaction is held in the input register, then its result loads the result register
// throughput: one transaction per cycle while out_ready is high; a waiting result leaves room
// for one more transaction in the input register, then in_ready drops until the result leaves
// duty changes reach the drive level through duty_reg and the registered level of lfds_duty_level
// reset: async active low, registers to defaults, all sequencer state to zero, no clearing pass

module led_frame_drive_sequencer_unit
    import lfds_pkg::*;
#(
    parameter int DELAY_ENTRIES = DELAY_ENTRIES_DEFAULT,
    parameter int SCAN_CHANNELS = SCAN_CHANNELS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_wr_en,
    input  logic [1:0]                cfg_index,
    input  logic [DUTY_W-1:0]         cfg_data,

    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                opcode,
    input  logic signed [REQ_W-1:0]   current_request,

    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [LEVEL_W-1:0]        drive_level,
    output logic [CUR_W-1:0]          peak_current,
    output logic                      low_current_flag,
    output logic                      scan_cmd_valid,
    output logic [1:0]                scan_cmd_value,
    output logic                      delay_cmd_valid,
    output logic [DELAY_W-1:0]        delay_cmd_value,
    output logic                      shutdown
);

    // configuration registers
    logic              low_mode_reg;
    logic              scan_test_reg;
    logic              delay_test_reg;
    logic [DUTY_W-1:0] duty_reg;
    logic [LEVEL_W-1:0] duty_level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_mode_reg   <= 1'b0;
            scan_test_reg  <= 1'b0;
            delay_test_reg <= 1'b0;
            duty_reg       <= DUTY_FULL;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_LOW_CURRENT: low_mode_reg   <= cfg_data[0];
                CFG_SCAN_TEST:   scan_test_reg  <= cfg_data[0];
                CFG_DELAY_TEST:  delay_test_reg <= cfg_data[0];
                CFG_DUTY:        duty_reg       <= cfg_data;
                default:         ;
            endcase
        end
    end

    lfds_duty_level u_duty_level (
        .clk   (clk),
        .rst_n (rst_n),
        .duty  (duty_reg),
        .level (duty_level)
    );

    // input register
    logic                    in_valid_reg;
    logic [1:0]              opcode_reg;
    logic [REQ_W-1:0]        request_reg;
    logic                    advance;

    assign advance  = in_valid_reg && (!out_valid || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            opcode_reg  <= opcode;
            request_reg <= current_request;
        end
    end

    // sequencer state
    scan_phase_t      scan_phase_reg, scan_phase_next;
    logic [6:0]       scan_tick_reg, scan_tick_next;
    logic [3:0]       scan_channel_reg, scan_channel_next;
    logic [8:0]       scan_level_reg, scan_level_next;
    logic [5:0]       delay_tick_reg, delay_tick_next;
    logic [3:0]       delay_index_reg, delay_index_next;
    logic [CUR_W-1:0] current_reg, current_next;
    logic [3:0]       step_reg, step_next;
    logic             halted_reg, halted_next;

    logic [LEVEL_W-1:0] res_drive;
    logic [CUR_W-1:0]   res_peak;
    logic               res_low;
    logic               res_scan_valid;
    logic [1:0]         res_scan_value;
    logic               res_delay_valid;
    logic [DELAY_W-1:0] res_delay_value;
    logic               res_shutdown;

    logic               stop;
    logic [4:0]         channel_inc;
    logic [4:0]         index_inc;
    logic [4:0]         step_inc;

    always_comb
    begin
        scan_phase_next   = scan_phase_reg;
        scan_tick_next    = scan_tick_reg;
        scan_channel_next = scan_channel_reg;
        scan_level_next   = scan_level_reg;
        delay_tick_next   = delay_tick_reg;
        delay_index_next  = delay_index_reg;
        current_next      = current_reg;
        step_next         = step_reg;
        halted_next       = halted_reg;

        res_drive       = '0;
        res_peak        = '0;
        res_low         = 1'b0;
        res_scan_valid  = 1'b0;
        res_scan_value  = '0;
        res_delay_valid = 1'b0;
        res_delay_value = '0;
        res_shutdown    = 1'b0;
        stop            = 1'b0;

        channel_inc = {1'b0, scan_channel_reg} + 5'd1;
        index_inc   = {1'b0, delay_index_reg} + 5'd1;
        step_inc    = {1'b0, step_reg} + 5'd1;

        if (!halted_reg)
        begin
            unique case (op_t'(opcode_reg))
                OP_TICK:
                begin
                    if (scan_test_reg)
                    begin
                        scan_tick_next = scan_tick_reg + 7'd1;
                        unique case (scan_phase_reg)
                            SCAN_WAIT_X8:
                            begin
                                if (scan_tick_next >= SCAN_WAIT)
                                begin
                                    res_scan_valid  = 1'b1;
                                    res_scan_value  = SCAN_CODE_X8;
                                    scan_level_next = SCAN_LEVEL_X8;
                                    current_next    = CUR_DEFAULT;
                                    scan_phase_next = SCAN_HOLD_X8;
                                    scan_tick_next  = '0;
                                end
                            end
                            SCAN_HOLD_X8:
                            begin
                                if (scan_tick_next >= SCAN_HOLD)
                                begin
                                    scan_level_next = '0;
                                    current_next    = '0;
                                    scan_phase_next = SCAN_WAIT_X1;
                                    scan_tick_next  = '0;
                                end
                            end
                            SCAN_WAIT_X1:
                            begin
                                if (scan_tick_next >= SCAN_WAIT)
                                begin
                                    res_scan_valid  = 1'b1;
                                    res_scan_value  = SCAN_CODE_X1;
                                    scan_level_next = SCAN_LEVEL_X1;
                                    current_next    = CUR_DEFAULT;
                                    scan_phase_next = SCAN_HOLD_X1;
                                    scan_tick_next  = '0;
                                end
                            end
                            SCAN_HOLD_X1:
                            begin
                                if (scan_tick_next >= SCAN_HOLD)
                                begin
                                    scan_level_next = '0;
                                    current_next    = '0;
                                    scan_phase_next = SCAN_WAIT_X8;
                                    scan_tick_next  = '0;
                                    if (channel_inc >= 5'(SCAN_CHANNELS))
                                    begin
                                        scan_channel_next = '0;
                                        stop              = 1'b1;
                                    end
                                    else
                                    begin
                                        scan_channel_next = channel_inc[3:0];
                                    end
                                end
                            end
                            default: ;
                        endcase
                        res_drive = {3'b0, scan_level_next};
                    end
                    else
                    begin
                        if (delay_test_reg)
                        begin
                            delay_tick_next = delay_tick_reg + 6'd1;
                            if (delay_tick_next > DELAY_PERIOD)
                            begin
                                res_delay_valid = 1'b1;
                                res_delay_value = delay_value(delay_index_reg);
                                delay_tick_next = '0;
                                // the index wraps in four bits before the compare
                                if ({1'b0, index_inc[3:0]} >= 5'(DELAY_ENTRIES))
                                begin
                                    delay_index_next = '0;
                                    stop             = 1'b1;
                                end
                                else
                                begin
                                    delay_index_next = index_inc[3:0];
                                end
                            end
                        end
                        res_drive = low_mode_reg ? LEVEL_LOW : duty_level;
                    end
                end
                OP_STEP:
                begin
                    current_next = (step_reg == 4'd0) ? '0
                                 : ({step_reg, 8'b0} - CUR_STEP_OFFSET);
                    step_next    = (step_inc > {1'b0, STEP_LAST}) ? '0 : step_inc[3:0];
                end
                OP_SET:
                begin
                    if (request_reg[REQ_W-1])
                    begin
                        current_next = '0;
                    end
                    else if (request_reg[REQ_W-2:0] > 15'(CUR_MAX))
                    begin
                        current_next = CUR_MAX;
                    end
                    else
                    begin
                        current_next = request_reg[CUR_W-1:0];
                    end
                end
                default: ;
            endcase

            res_peak = current_next;
            res_low  = low_mode_reg;

            if (stop)
            begin
                halted_next  = 1'b1;
                current_next = '0;
                step_next    = '0;
                res_drive    = '0;
                res_peak     = '0;
                res_low      = 1'b0;
                res_shutdown = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_phase_reg   <= SCAN_WAIT_X8;
            scan_tick_reg    <= '0;
            scan_channel_reg <= '0;
            scan_level_reg   <= '0;
            delay_tick_reg   <= '0;
            delay_index_reg  <= '0;
            current_reg      <= '0;
            step_reg         <= '0;
            halted_reg       <= 1'b0;
        end
        else if (advance)
        begin
            scan_phase_reg   <= scan_phase_next;
            scan_tick_reg    <= scan_tick_next;
            scan_channel_reg <= scan_channel_next;
            scan_level_reg   <= scan_level_next;
            delay_tick_reg   <= delay_tick_next;
            delay_index_reg  <= delay_index_next;
            current_reg      <= current_next;
            step_reg         <= step_next;
            halted_reg       <= halted_next;
        end
    end

    // result register
    logic out_valid_reg;
    logic out_valid_next;

    assign out_valid_next = advance || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            drive_level      <= res_drive;
            peak_current     <= res_peak;
            low_current_flag <= res_low;
            scan_cmd_valid   <= res_scan_valid;
            scan_cmd_value   <= res_scan_value;
            delay_cmd_valid  <= res_delay_valid;
            delay_cmd_value  <= res_delay_value;
            shutdown         <= res_shutdown;
        end
    end

    assign out_valid = out_valid_reg;

    a_halted_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halted state cleared without reset");

    a_halted_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && halted_reg) |=>
            (drive_level == '0 && peak_current == '0 && !shutdown
             && !scan_cmd_valid && !delay_cmd_valid))
        else $error("result after halt is not all zero");

    a_shutdown_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_shutdown) |=> halted_reg)
        else $error("shutdown result without entering halt");

    a_current_range: assert property (@(posedge clk) disable iff (!rst_n)
        current_reg <= CUR_MAX)
        else $error("current setting above maximum");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(scan_cmd_valid && delay_cmd_valid))
        else $error("scan and delay commands in one result");

endmodule

FILE: sv/lfds_duty_level.sv
// lfds_duty_level: registered conversion of the duty register to a drive level
// depends on lfds_pkg

module lfds_duty_level
    import lfds_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [DUTY_W-1:0]  duty,
    output logic [LEVEL_W-1:0] level
);

    logic [DUTY_W-1:0]  duty_clamped;
    logic [25:0]        numerator;
    logic [52:0]        product;
    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_next;

    always_comb
    begin
        duty_clamped = (duty > DUTY_FULL) ? DUTY_FULL : duty;
        numerator    = {duty_clamped, 12'b0} - 26'(duty_clamped) + DUTY_HALF;
        product      = 53'(numerator) * 53'(DUTY_RECIP);
        level_next   = product[DUTY_SHIFT +: LEVEL_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= LEVEL_MAX;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

    assign level = level_reg;

endmodule

FILE: verif/lfds_drive_checker.sv
// lfds_drive_checker: watches the item and result channels of the LED frame drive sequencer,
// predicts every result from its own copy of the sequencer state and compares field by field
// depends on lfds_pkg for widths, codes and constants

module lfds_drive_checker
    import lfds_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_wr_en,
    input  logic [1:0]              cfg_index,
    input  logic [DUTY_W-1:0]       cfg_data,

    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic [1:0]              opcode,
    input  logic signed [REQ_W-1:0] current_request,

    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic [LEVEL_W-1:0]      drive_level,
    input  logic [CUR_W-1:0]        peak_current,
    input  logic                    low_current_flag,
    input  logic                    scan_cmd_valid,
    input  logic [1:0]              scan_cmd_value,
    input  logic                    delay_cmd_valid,
    input  logic [DELAY_W-1:0]      delay_cmd_value,
    input  logic                    shutdown,

    output int                      fail_count,
    output int                      pending_count,
    output int                      checked_count
);

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [CUR_W-1:0]   peak;
        logic               low_flag;
        logic               scan_valid;
        logic [1:0]         scan_code;
        logic               delay_valid;
        logic [DELAY_W-1:0] delay_value;
        logic               shutdown_req;
    } drive_result_t;

    drive_result_t expected_drive_q[$];

    int fails = 0;
    int checked = 0;

    // configuration copy
    logic               low_mode;
    logic               scan_en;
    logic               delay_en;
    logic [DUTY_W-1:0]  duty;

    // sequencer state copy
    scan_phase_t        scan_phase;
    logic [6:0]         scan_ticks;
    logic [3:0]         scan_chan;
    logic [8:0]         scan_lvl;
    logic [5:0]         delay_ticks;
    logic [3:0]         delay_idx;
    logic [CUR_W-1:0]   cur_level;
    logic [3:0]         step_cnt;
    logic               halted;

    function automatic logic [LEVEL_W-1:0] duty_to_level(input logic [DUTY_W-1:0] d);
        int unsigned x;
        x = 32'(d);
        if (x > DUTY_FULL)
            x = 32'(DUTY_FULL);
        return LEVEL_W'((x * LEVEL_MAX + DUTY_HALF) / DUTY_FULL);
    endfunction

    // 0, then powers of two from 1 up to 2048 for the last entry and beyond
    function automatic logic [DELAY_W-1:0] line_delay_entry(input logic [3:0] idx);
        if (idx == 4'd0)
            return '0;
        if (idx >= 4'd12)
            return 12'd2048;
        return 12'd1 << (idx - 4'd1);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        fails++;
    endtask

    task automatic compare_field(input string name, input logic [11:0] got,
                                 input logic [11:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s is %0d, expected %0d",
                                      checked, name, got, want));
    endtask

    task automatic scan_frame(inout drive_result_t r, inout bit stop);
        scan_ticks = scan_ticks + 7'd1;
        case (scan_phase)
            SCAN_WAIT_X8:
                if (scan_ticks >= SCAN_WAIT)
                begin
                    r.scan_valid = 1'b1;
                    r.scan_code = SCAN_CODE_X8;
                    scan_lvl = SCAN_LEVEL_X8;
                    cur_level = CUR_DEFAULT;
                    scan_phase = SCAN_HOLD_X8;
                    scan_ticks = '0;
                end
            SCAN_HOLD_X8:
                if (scan_ticks >= SCAN_HOLD)
                begin
                    scan_lvl = '0;
                    cur_level = '0;
                    scan_phase = SCAN_WAIT_X1;
                    scan_ticks = '0;
                end
            SCAN_WAIT_X1:
                if (scan_ticks >= SCAN_WAIT)
                begin
                    r.scan_valid = 1'b1;
                    r.scan_code = SCAN_CODE_X1;
                    scan_lvl = SCAN_LEVEL_X1;
                    cur_level = CUR_DEFAULT;
                    scan_phase = SCAN_HOLD_X1;
                    scan_ticks = '0;
                end
            default:
                if (scan_ticks >= SCAN_HOLD)
                begin
                    scan_lvl = '0;
                    cur_level = '0;
                    scan_phase = SCAN_WAIT_X8;
                    scan_ticks = '0;
                    scan_chan = scan_chan + 4'd1;
                    if (scan_chan >= SCAN_CHANNELS_DEFAULT)
                    begin
                        scan_chan = '0;
                        stop = 1'b1;
                    end
                end
        endcase
        r.level = LEVEL_W'(scan_lvl);
    endtask

    task automatic delay_frame(inout drive_result_t r, inout bit stop);
        delay_ticks = delay_ticks + 6'd1;
        if (delay_ticks > DELAY_PERIOD)
        begin
            r.delay_valid = 1'b1;
            r.delay_value = line_delay_entry(delay_idx);
            delay_idx = delay_idx + 4'd1;
            if (delay_idx >= DELAY_ENTRIES_DEFAULT)
            begin
                delay_idx = '0;
                stop = 1'b1;
            end
            delay_ticks = '0;
        end
    endtask

    task automatic predict_drive(input logic [1:0] op, input logic [REQ_W-1:0] req,
                                 output drive_result_t r);
        bit stop;
        int unsigned n;
        r = '0;
        stop = 1'b0;
        if (halted)
            return;
        case (op)
            OP_TICK:
                if (scan_en)
                    scan_frame(r, stop);
                else
                begin
                    if (delay_en)
                        delay_frame(r, stop);
                    r.level = low_mode ? LEVEL_LOW : duty_to_level(duty);
                end
            OP_STEP:
            begin
                n = 32'(step_cnt);
                cur_level = (n == 0) ? '0 : CUR_W'((16 * n - 1) * 16);
                n++;
                step_cnt = (n > STEP_LAST) ? '0 : 4'(n);
            end
            OP_SET:
                if (req[REQ_W-1])
                    cur_level = '0;
                else if (req > CUR_MAX)
                    cur_level = CUR_MAX;
                else
                    cur_level = req[CUR_W-1:0];
            default: ;
        endcase
        r.peak = cur_level;
        r.low_flag = low_mode;
        if (stop)
        begin
            halted = 1'b1;
            cur_level = '0;
            step_cnt = '0;
            r.level = '0;
            r.peak = '0;
            r.low_flag = 1'b0;
            r.shutdown_req = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        drive_result_t seen;
        drive_result_t want;
        if (!rst_n)
        begin
            low_mode = 1'b0;
            scan_en = 1'b0;
            delay_en = 1'b0;
            duty = DUTY_FULL;
            scan_phase = SCAN_WAIT_X8;
            scan_ticks = '0;
            scan_chan = '0;
            scan_lvl = '0;
            delay_ticks = '0;
            delay_idx = '0;
            cur_level = '0;
            step_cnt = '0;
            halted = 1'b0;
            expected_drive_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen = {drive_level, peak_current, low_current_flag, scan_cmd_valid,
                        scan_cmd_value, delay_cmd_valid, delay_cmd_value, shutdown};
                if (expected_drive_q.size() == 0)
                    report_mismatch("result transaction with no prediction pending");
                else
                begin
                    want = expected_drive_q.pop_front();
                    checked++;
                    compare_field("drive_level", seen.level, want.level);
                    compare_field("peak_current", seen.peak, want.peak);
                    compare_field("low_current_flag", 12'(seen.low_flag), 12'(want.low_flag));
                    compare_field("scan_cmd_valid", 12'(seen.scan_valid),
                                  12'(want.scan_valid));
                    compare_field("scan_cmd_value", 12'(seen.scan_code), 12'(want.scan_code));
                    compare_field("delay_cmd_valid", 12'(seen.delay_valid),
                                  12'(want.delay_valid));
                    compare_field("delay_cmd_value", seen.delay_value, want.delay_value);
                    compare_field("shutdown", 12'(seen.shutdown_req), 12'(want.shutdown_req));
                end
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_LOW_CURRENT: low_mode = cfg_data[0];
                    CFG_SCAN_TEST:   scan_en = cfg_data[0];
                    CFG_DELAY_TEST:  delay_en = cfg_data[0];
                    default:         duty = cfg_data;
                endcase
            end
            if (in_valid && in_ready)
            begin
                predict_drive(opcode, current_request, want);
                expected_drive_q.push_back(want);
            end
        end
        fail_count <= fails;
        pending_count <= expected_drive_q.size();
        checked_count <= checked;
    end

endmodule

FILE: verif/led_frame_drive_sequencer_unit_test.sv
// led_frame_drive_sequencer_unit_test: stimulus and verdict for the LED frame drive sequencer
// drives directed and random transactions through normal, scan-test and line-delay settings
// depends on lfds_pkg, led_frame_drive_sequencer_unit and lfds_drive_checker

module led_frame_drive_sequencer_unit_test;
    import lfds_pkg::*;

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int LONG_HOLD_CYCLES = 90;
    localparam int HALTED_ITEMS     = 16;
    localparam int DELAY_SWEEP_TICKS = DELAY_ENTRIES_DEFAULT * (int'(DELAY_PERIOD) + 1);
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [1:0]              cfg_index = CFG_LOW_CURRENT;
    logic [DUTY_W-1:0]       cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [1:0]              opcode = OP_TICK;
    logic signed [REQ_W-1:0] current_request = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [LEVEL_W-1:0]      drive_level;
    logic [CUR_W-1:0]        peak_current;
    logic                    low_current_flag;
    logic                    scan_cmd_valid;
    logic [1:0]              scan_cmd_value;
    logic                    delay_cmd_valid;
    logic [DELAY_W-1:0]      delay_cmd_value;
    logic                    shutdown;

    int fail_count;
    int pending_count;
    int checked_count;

    int    hold_requests = 0;
    int    hold_served = 0;
    bit    tx_gaps = 1'b0;
    bit    rx_gaps = 1'b0;
    int    items_sent = 0;
    int    scan_tick_total = 0;
    int    delay_tick_total = 0;
    bit    shadow_scan = 1'b0;
    bit    shadow_delay = 1'b0;
    int    stall_cycles = 0;

    led_frame_drive_sequencer_unit DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .opcode           (opcode),
        .current_request  (current_request),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .drive_level      (drive_level),
        .peak_current     (peak_current),
        .low_current_flag (low_current_flag),
        .scan_cmd_valid   (scan_cmd_valid),
        .scan_cmd_value   (scan_cmd_value),
        .delay_cmd_valid  (delay_cmd_valid),
        .delay_cmd_value  (delay_cmd_value),
        .shutdown         (shutdown)
    );

    lfds_drive_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .opcode           (opcode),
        .current_request  (current_request),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .drive_level      (drive_level),
        .peak_current     (peak_current),
        .low_current_flag (low_current_flag),
        .scan_cmd_valid   (scan_cmd_valid),
        .scan_cmd_value   (scan_cmd_value),
        .delay_cmd_valid  (delay_cmd_valid),
        .delay_cmd_value  (delay_cmd_value),
        .shutdown         (shutdown),
        .fail_count       (fail_count),
        .pending_count    (pending_count),
        .checked_count    (checked_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int gap_length();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [DUTY_W-1:0] pick_duty();
        if ($urandom_range(0, 9) < 4)
        begin
            case ($urandom_range(0, 7))
                0:       return 14'd0;
                1:       return 14'd1;
                2:       return 14'd4999;
                3:       return 14'd5000;
                4:       return 14'd9999;
                5:       return DUTY_FULL;
                6:       return 14'd10001;
                default: return 14'd16383;
            endcase
        end
        return 14'($urandom_range(0, 16383));
    endfunction

    function automatic logic [REQ_W-1:0] pick_request();
        if ($urandom_range(0, 9) < 3)
        begin
            case ($urandom_range(0, 7))
                0:       return 16'h8000;
                1:       return 16'hFFFF;
                2:       return 16'd0;
                3:       return 16'd1;
                4:       return 16'd2047;
                5:       return 16'd2048;
                6:       return 16'd2049;
                default: return 16'h7FFF;
            endcase
        end
        return 16'($urandom);
    endfunction

    function automatic bit coin();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic pause_cycles(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_item(input logic [1:0] op, input logic [REQ_W-1:0] req);
        in_valid <= 1'b1;
        opcode <= op;
        current_request <= req;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        if (op == OP_TICK)
        begin
            if (shadow_scan)
                scan_tick_total++;
            else if (shadow_delay)
                delay_tick_total++;
        end
        if (tx_gaps && $urandom_range(0, 3) == 0)
            pause_cycles(gap_length());
    endtask

    task automatic send_random(input int tick_pct);
        logic [1:0] op;
        op = ($urandom_range(0, 99) < tick_pct) ? OP_TICK : 2'($urandom_range(1, 3));
        send_item(op, pick_request());
    endtask

    task automatic random_items(input int n, input int tick_pct);
        repeat (n) send_random(tick_pct);
    endtask

    // wait until every predicted result has come back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [DUTY_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic apply_settings(input bit low, input bit scan, input bit dly,
                                  input logic [DUTY_W-1:0] duty);
        write_reg(CFG_LOW_CURRENT, {13'($urandom_range(0, 8191)), low});
        write_reg(CFG_SCAN_TEST, {13'($urandom_range(0, 8191)), scan});
        write_reg(CFG_DELAY_TEST, {13'($urandom_range(0, 8191)), dly});
        write_reg(CFG_DUTY, duty);
        cfg_wr_en <= 1'b0;
        shadow_scan = scan;
        shadow_delay = dly;
        repeat (2) @(posedge clk);
    endtask

    task automatic new_phase(input bit low, input bit scan, input bit dly,
                             input logic [DUTY_W-1:0] duty);
        drain();
        apply_settings(low, scan, dly, duty);
        tx_gaps = ($urandom_range(0, 3) != 0);
        rx_gaps = ($urandom_range(0, 3) != 0);
    endtask

    // receiver side: random back-pressure plus one long hold on request
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requests)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                hold_served++;
            end
            else if (rx_gaps && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat (gap_length() - 1) @(posedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("led_frame_drive_sequencer_unit regression: fail");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, current requests at the edges, step wrap, unused opcode
        send_item(OP_TICK, 16'd0);
        send_item(OP_SET, 16'd0);
        send_item(OP_SET, 16'd1);
        send_item(OP_SET, 16'd2047);
        send_item(OP_SET, 16'd2048);
        send_item(OP_SET, 16'd2049);
        send_item(OP_SET, 16'd4095);
        send_item(OP_SET, 16'h7FFF);
        send_item(OP_SET, 16'hFFFF);
        send_item(OP_SET, 16'h8000);
        repeat (10) send_item(OP_STEP, 16'($urandom));
        send_item(OP_UNUSED, 16'h7FFF);
        send_item(OP_TICK, 16'hFFFF);
        drain();
        apply_settings(1'b1, 1'b0, 1'b0, DUTY_FULL);
        send_item(OP_TICK, 16'd0);
        send_item(OP_SET, 16'd100);

        // normal drive with random settings, line delay on in most phases
        for (int p = 0; p < 6; p++)
        begin
            new_phase(coin(), 1'b0, (p != 0 && p != 3), pick_duty());
            if (p == 0)
            begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            if (p == 3)
            begin
                tx_gaps = 1'b0;
                hold_requests++;
            end
            random_items(12, 60);
        end

        // scan test partway, state kept across rewrites
        for (int p = 0; p < 2; p++)
        begin
            new_phase(coin(), 1'b1, coin(), pick_duty());
            random_items(75, 96);
        end
        new_phase(coin(), 1'b0, 1'b0, pick_duty());
        random_items(10, 50);

        // line-delay test run to completion
        while (delay_tick_total < DELAY_SWEEP_TICKS)
        begin
            new_phase(coin(), 1'b0, 1'b1, pick_duty());
            for (int i = 0; i < 150 && delay_tick_total < DELAY_SWEEP_TICKS; i++)
                send_random(96);
        end

        // block is halted now; everything after must come back as zeros
        new_phase(coin(), coin(), coin(), pick_duty());
        random_items(HALTED_ITEMS, 50);
        drain();
        repeat (10) @(posedge clk);

        $display("%0d transactions sent, %0d results checked, %0d scan ticks, %0d delay ticks",
                 items_sent, checked_count, scan_tick_total, delay_tick_total);
        $display("line-delay test run through shutdown, then %0d transactions while halted",
                 HALTED_ITEMS);
        if (fail_count == 0 && pending_count == 0)
            $display("led_frame_drive_sequencer_unit regression: pass");
        else
            $display("led_frame_drive_sequencer_unit regression: fail");
        $finish;
    end

endmodule
